### sv/dgsp_pkg.sv
// Shared types and constants for the dense graph shortest path unit.
`timescale 1ns / 1ps

package dgsp_pkg;

  // Parameter defaults
  localparam int MAX_NODES_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 10;

  // Fixed field widths
  localparam int NODE_W     = 8;
  localparam int WEIGHT_W   = 10;
  localparam int PATH_W     = 18;
  localparam int CFG_W      = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 9'd256;

  // Command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Query request from the command front end to the search engine
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] source;
    logic [NODE_W-1:0] target;
  } qreq_t;

  // Query result from the search engine
  typedef struct packed {
    logic              valid;
    logic              unreachable;
    logic [PATH_W-1:0] path_length;
  } qres_t;

endpackage

### sv/dense_graph_shortest_path_unit.sv
// Top level of the dense graph shortest path unit.
`timescale 1ns / 1ps

// The unit keeps a directed weighted graph of up to MAX_NODES nodes as an
// adjacency matrix in an edge RAM of 2^(2*clog2(MAX_NODES)) entries, and
// takes one command per input item: clear all edges, write one edge, or
// query the shortest distance between two nodes among the first node_count
// nodes. Only a query returns a result item. A clear sweeps the whole edge
// RAM, one entry a cycle, and the same sweep runs after reset before the
// first item is taken; configuration writes are taken at any time. A query
// with n nodes in use first initialises the distance RAM, then settles one
// node per pass (at most n passes), each pass walking through the distance
// RAM by its single read port, and last fetches the result. One item is
// worked on at a time; a finished result waits in the output register
// while writes and clears go on.

module dense_graph_shortest_path_unit #(
  parameter int MAX_NODES   = dgsp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] source_node, [15:8] target_node, [25:16] edge_weight
  input  logic [dgsp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]                      in_tuser,
  // Result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [17:0] path_length
  output logic [dgsp_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] unreachable
  output logic                            out_tuser,
  // Configuration: node_count
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dgsp_pkg::CFG_W-1:0]      cfg_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = NW + 1;
  localparam int AW = 2 * NW;
  localparam int EW = WEIGHT_BITS + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]                  clr_addr_r, clr_addr_nxt;
  logic [dgsp_pkg::CFG_W-1:0]     node_count_r;
  logic [CW-1:0]                  node_cnt;
  logic                           out_tvalid_r;
  logic                           out_unr_r;
  logic [dgsp_pkg::PATH_W-1:0]    out_path_r;

  logic                           in_acc;
  dgsp_pkg::cmd_t                 cmd;
  logic [dgsp_pkg::NODE_W-1:0]    in_src;
  logic [dgsp_pkg::NODE_W-1:0]    in_dst;
  logic [dgsp_pkg::WEIGHT_W-1:0]  in_weight;
  logic                           wr_in_range;

  logic                           edge_we;
  logic [AW-1:0]                  edge_waddr;
  logic [EW-1:0]                  edge_wdata;
  logic [AW-1:0]                  edge_raddr;
  logic [EW-1:0]                  edge_rdata;

  dgsp_pkg::qreq_t                req;
  dgsp_pkg::qres_t                res;
  logic                           res_take;

  // Unpack the item
  assign in_acc      = in_tvalid && in_tready;
  assign cmd         = dgsp_pkg::cmd_t'(in_tuser);
  assign in_src      = in_tdata[7:0];
  assign in_dst      = in_tdata[15:8];
  assign in_weight   = in_tdata[25:16];
  assign wr_in_range = (32'(in_src) < MAX_NODES) && (32'(in_dst) < MAX_NODES);
  assign in_tready   = (state_r == ST_IDLE);

  // Clamp the node count to one up to MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      node_cnt = CW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      node_cnt = CW'(MAX_NODES);
    end else begin
      node_cnt = CW'(node_count_r);
    end
  end

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= dgsp_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // Edge RAM: {present, weight}
  dgsp_ram #(
    .WIDTH (EW),
    .DEPTH (1 << AW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // Shortest path search
  assign req.valid  = in_acc && (cmd == dgsp_pkg::CMD_QUERY);
  assign req.source = in_src;
  assign req.target = in_dst;

  dgsp_search #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .node_cnt   (node_cnt),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .res        (res),
    .res_ready  (res_take)
  );

  // Hand a result over when the output register is free or draining
  assign res_take = res.valid && (!out_tvalid_r || out_tready);

  // Command control and edge RAM writes
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    edge_we      = 1'b0;
    edge_waddr   = clr_addr_r;
    edge_wdata   = '0;
    case (state_r)
      ST_CLEAR: begin
        edge_we = 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            dgsp_pkg::CMD_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            dgsp_pkg::CMD_WRITE: begin
              edge_we    = wr_in_range;
              edge_waddr = {NW'(in_src), NW'(in_dst)};
              edge_wdata = {1'b1, WEIGHT_BITS'(in_weight)};
            end
            dgsp_pkg::CMD_QUERY: begin
              state_nxt = ST_QUERY;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_QUERY: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (res_take) begin
      out_unr_r  <= res.unreachable;
      out_path_r <= res.path_length;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_unr_r;
  assign out_tdata  = {{(dgsp_pkg::OUT_DATA_W - dgsp_pkg::PATH_W){1'b0}}, out_path_r};

endmodule

### sv/dgsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module dgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dgsp_search.sv
// Search engine: settles nodes one pass at a time over a distance RAM.
`timescale 1ns / 1ps

module dgsp_search #(
  parameter int MAX_NODES   = dgsp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF,
  localparam int NW = $clog2(MAX_NODES),
  localparam int CW = NW + 1,
  localparam int AW = 2 * NW,
  localparam int EW = WEIGHT_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dgsp_pkg::qreq_t   req,
  input  logic [CW-1:0]     node_cnt,
  output logic [AW-1:0]     edge_raddr,
  input  logic [EW-1:0]     edge_rdata,
  output dgsp_pkg::qres_t   res,
  input  logic              res_ready
);

  localparam int DW    = NW + WEIGHT_BITS;
  localparam int ENT_W = DW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PASS,
    S_SEL,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [NW-1:0] src_r, src_nxt;
  logic [NW-1:0] dst_r, dst_nxt;
  logic [NW-1:0] v_r, v_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [NW-1:0] next_r, next_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [NW-1:0] p_idx_r, p_idx_nxt;
  logic          unr_r, unr_nxt;
  logic [dgsp_pkg::PATH_W-1:0] path_r, path_nxt;

  // Distance RAM: {visited, valid, distance}
  logic             dist_we;
  logic [NW-1:0]    dist_waddr;
  logic [ENT_W-1:0] dist_wdata;
  logic [NW-1:0]    dist_raddr;
  logic [ENT_W-1:0] dist_rdata;

  dgsp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NODES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  // Relaxation of the entry whose data has just come back
  logic                   ent_vis;
  logic                   ent_val;
  logic [DW-1:0]          ent_d;
  logic                   e_pres;
  logic [WEIGHT_BITS-1:0] e_w;
  logic [DW-1:0]          cand;
  logic                   relax;
  logic                   new_vis;
  logic                   new_val;
  logic [DW-1:0]          new_d;
  logic                   pick;
  logic                   issue;

  assign ent_vis = dist_rdata[DW+1];
  assign ent_val = dist_rdata[DW];
  assign ent_d   = dist_rdata[DW-1:0];
  assign e_pres  = edge_rdata[WEIGHT_BITS];
  assign e_w     = edge_rdata[WEIGHT_BITS-1:0];
  assign cand    = dv_r + DW'(e_w);
  assign relax   = e_pres && (!ent_val || (ent_d > cand));
  assign new_vis = ent_vis | (p_idx_r == v_r);
  assign new_val = ent_val | relax;
  assign new_d   = relax ? cand : ent_d;
  assign pick    = !new_vis && new_val && (!found_r || (new_d < best_r));
  assign issue   = (rd_idx_r < node_cnt);

  // Row of the node being settled, column in step with the distance read
  assign edge_raddr = {v_r, rd_idx_r[NW-1:0]};

  assign res.valid       = (state_r == S_DONE);
  assign res.unreachable = unr_r;
  assign res.path_length = path_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    v_nxt      = v_r;
    dv_nxt     = dv_r;
    best_nxt   = best_r;
    next_nxt   = next_r;
    found_nxt  = found_r;
    rd_idx_nxt = rd_idx_r;
    p_vld_nxt  = 1'b0;
    p_idx_nxt  = p_idx_r;
    unr_nxt    = unr_r;
    path_nxt   = path_r;
    dist_we    = 1'b0;
    dist_waddr = p_idx_r;
    dist_wdata = {new_vis, new_val, new_d};
    dist_raddr = rd_idx_r[NW-1:0];
    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          src_nxt    = NW'(req.source);
          dst_nxt    = NW'(req.target);
          rd_idx_nxt = '0;
          if ((32'(req.source) >= 32'(node_cnt)) || (32'(req.target) >= 32'(node_cnt))) begin
            unr_nxt   = 1'b1;
            path_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // Clear every entry in use, the origin marked reached at distance zero
        dist_we    = 1'b1;
        dist_waddr = rd_idx_r[NW-1:0];
        dist_wdata = {1'b0, (rd_idx_r[NW-1:0] == src_r), DW'(0)};
        if ((rd_idx_r + CW'(1)) == node_cnt) begin
          rd_idx_nxt = '0;
          v_nxt      = src_r;
          dv_nxt     = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_PASS;
        end else begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end
      S_PASS: begin
        // Issue one read a cycle, relax and write back in the following cycle
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        p_vld_nxt = issue;
        p_idx_nxt = rd_idx_r[NW-1:0];
        if (p_vld_r) begin
          dist_we = 1'b1;
          if (pick) begin
            found_nxt = 1'b1;
            best_nxt  = new_d;
            next_nxt  = p_idx_r;
          end
        end
        if (!issue && !p_vld_r) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        // Settle the chosen node, or fetch the target distance when none is left
        if (found_r) begin
          v_nxt      = next_r;
          dv_nxt     = best_r;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_PASS;
        end else begin
          dist_raddr = dst_r;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        if (ent_val) begin
          unr_nxt  = 1'b0;
          path_nxt = dgsp_pkg::PATH_W'(ent_d);
        end else begin
          unr_nxt  = 1'b1;
          path_nxt = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      p_vld_r <= p_vld_nxt;
    end
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    v_r      <= v_nxt;
    dv_r     <= dv_nxt;
    best_r   <= best_nxt;
    next_r   <= next_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_idx_r  <= p_idx_nxt;
    unr_r    <= unr_nxt;
    path_r   <= path_nxt;
  end

endmodule
